[rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reducer.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPW = 16;           // operand width
    localparam int PW  = 2 * OPW;      // product width
    localparam int RW  = PW + 1;       // raw sum width (signed)
    localparam int MW  = PW;           // magnitude width (same as the product width)
    localparam int OW  = 33;           // output word width
    localparam int CW  = $clog2(MW + 2);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // queue entry between front and back
    typedef struct packed {
        logic          neg_n;
        logic          neg_d;
        logic [RW-1:0] mag_n;
        logic [RW-1:0] mag_d;
    } raw_t;

endpackage

[rtl/rar_front.sv]
// ----------------------------------------------------------------------------
// rar_front
// Accepts a word, forms raw numerator and denominator on one multiplier
// in states M0, M1 and (add/sub) M2, and pushes signs and magnitudes to the queue.
// ----------------------------------------------------------------------------
module rar_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid,
    output logic                            ready,
    input  logic [1:0]                      operation,
    input  logic signed [rar_pkg::OPW-1:0]  num_a,
    input  logic signed [rar_pkg::OPW-1:0]  den_a,
    input  logic signed [rar_pkg::OPW-1:0]  num_b,
    input  logic signed [rar_pkg::OPW-1:0]  den_b,
    output logic                            q_valid,
    input  logic                            q_ready,
    output rar_pkg::raw_t                   q_data
);
    import rar_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            op_reg;
    logic signed [OPW-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic signed [PW-1:0]  p_reg;
    logic signed [RW-1:0]  rn_reg, rd_reg;
    logic signed [OPW-1:0] ma, mb;
    logic signed [PW-1:0]  prod;
    raw_t                  q_word;

    always_comb
    begin
        ma = na_reg;
        mb = db_reg;
        case (state_reg)
            S_M0:
            begin
                ma = na_reg;
                mb = (op_reg == OP_MUL) ? nb_reg : db_reg;
            end
            S_M1:
            begin
                ma = da_reg;
                mb = (op_reg == OP_DIV) ? nb_reg : db_reg;
            end
            S_M2:
            begin
                ma = nb_reg;
                mb = da_reg;
            end
            default:
            begin
                ma = na_reg;
                mb = db_reg;
            end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (valid) state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = (op_reg == OP_ADD || op_reg == OP_SUB) ? S_M2 : S_PUSH;
            S_M2:   state_next = S_PUSH;
            S_PUSH: if (q_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= operation;
                na_reg <= num_a;
                da_reg <= den_a;
                nb_reg <= num_b;
                db_reg <= den_b;
            end
            S_M0: p_reg <= prod;
            S_M1:
            begin
                rd_reg <= RW'(prod);
                rn_reg <= RW'(p_reg);
            end
            S_M2:
            begin
                if (op_reg == OP_SUB)
                    rn_reg <= rn_reg - RW'(prod);
                else
                    rn_reg <= rn_reg + RW'(prod);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        q_word.neg_n = rn_reg[RW-1];
        q_word.neg_d = rd_reg[RW-1];
        q_word.mag_n = rn_reg[RW-1] ? -rn_reg : rn_reg;
        q_word.mag_d = rd_reg[RW-1] ? -rd_reg : rd_reg;
    end

    assign ready   = (state_reg == S_IDLE);
    assign q_valid = (state_reg == S_PUSH);
    assign q_data  = q_word;

endmodule

[rtl/rar_queue.sv]
// ----------------------------------------------------------------------------
// rar_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rar_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rar_pkg::raw_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rar_pkg::raw_t rd_data
);
    import rar_pkg::*;

    raw_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count out of range");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("push lost");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop lost");
`endif

endmodule

[rtl/rar_back.sv]
// ----------------------------------------------------------------------------
// rar_back
// Binary GCD of the two magnitudes, then two restoring divisions by the
// GCD on one shared subtractor, then the signed output register.
// ----------------------------------------------------------------------------
module rar_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  rar_pkg::raw_t                  q_data,
    output logic                           valid,
    input  logic                           ready,
    output logic signed [rar_pkg::OW-1:0]  num_out,
    output logic signed [rar_pkg::OW-1:0]  den_out
);
    import rar_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    raw_t          it_reg;
    logic [RW-1:0] a_reg, b_reg;      // gcd working values
    logic [CW-1:0] k_reg;             // common factor-of-two count
    logic [RW-1:0] g_reg;             // gcd
    logic [RW-1:0] rem_reg, quo_reg;
    logic [CW:0]   cnt_reg;
    logic [RW-1:0] qn_reg;
    logic [RW:0]   trial;
    logic [RW-1:0] rem_sh;

    assign rem_sh = {rem_reg[RW-2:0], quo_reg[RW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, g_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_GCD;
            S_GCD:  if (a_reg == b_reg || a_reg == '0 || b_reg == '0) state_next = S_DIVN;
            S_DIVN: if (cnt_reg == '0) state_next = S_DIVD;
            S_DIVD: if (cnt_reg == '0) state_next = S_OUT;
            S_OUT:  if (ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Load, binary GCD (strip shared twos, strip lone twos, subtract smaller from larger), divisions, output.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                it_reg <= q_data;
                a_reg  <= q_data.mag_n;
                b_reg  <= q_data.mag_d;
                k_reg  <= '0;
            end
            S_GCD:
            begin
                if (a_reg == '0 || b_reg == '0)
                    g_reg <= RW'(1);
                else if (a_reg == b_reg)
                    g_reg <= a_reg << k_reg;
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!a_reg[0])
                    a_reg <= a_reg >> 1;
                else if (!b_reg[0])
                    b_reg <= b_reg >> 1;
                else if (a_reg > b_reg)
                    a_reg <= (a_reg - b_reg) >> 1;
                else
                    b_reg <= (b_reg - a_reg) >> 1;
                if (state_next == S_DIVN)
                begin
                    rem_reg <= '0;
                    quo_reg <= it_reg.mag_n;
                    cnt_reg <= (CW+1)'(RW - 1);
                end
            end
            S_DIVN, S_DIVD:
            begin
                if (cnt_reg == '0)
                begin
                    // last quotient bit goes straight to its destination
                    if (state_reg == S_DIVN)
                    begin
                        qn_reg  <= {quo_reg[RW-2:0], !trial[RW]};
                        rem_reg <= '0;
                        quo_reg <= it_reg.mag_d;
                        cnt_reg <= (CW+1)'(RW - 1);
                    end
                    else
                    begin
                        num_out <= it_reg.neg_n ? -OW'(qn_reg) : OW'(qn_reg);
                        den_out <= it_reg.neg_d ? -OW'({quo_reg[RW-2:0], !trial[RW]})
                                                : OW'({quo_reg[RW-2:0], !trial[RW]});
                    end
                end
                else
                begin
                    if (!trial[RW])
                    begin
                        rem_reg <= trial[RW-1:0];
                        quo_reg <= {quo_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[RW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign q_ready = (state_reg == S_IDLE);
    assign valid   = (state_reg == S_OUT);

`ifndef SYNTHESIS
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVN |-> g_reg != '0) else $error("zero divisor");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(num_out) && $stable(den_out))
        else $error("result changed while stalled");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> state_reg == S_GCD) else $error("queue pop lost");
`endif

endmodule

[rtl/rational_arith_reduce.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Signed fraction add/subtract/multiply/divide with GCD reduction.
// ----------------------------------------------------------------------------
// Input channel (valid/ready) takes operation and two fractions a and b.
// Output channel (valid/ready) returns num_out/den_out, each reduced by the
// GCD of the raw magnitudes and keeping its own raw sign; a zero magnitude
// on either side passes both through unreduced.
// Front: one 16x16 multiplier, one word at a time, then a 2-word queue.
// Back: binary GCD (one shift or subtract per cycle) then two 33-step
// restoring divisions sharing one subtractor, one word at a time; the back
// unit sets the throughput. The front keeps accepting while the queue has
// room, so a stalled receiver first fills the queue, then drops ready on
// the input. Reset clears all control state and empties the queue.
// ----------------------------------------------------------------------------
module rational_arith_reduce
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      operation,
    input  logic signed [rar_pkg::OPW-1:0]  num_a,
    input  logic signed [rar_pkg::OPW-1:0]  den_a,
    input  logic signed [rar_pkg::OPW-1:0]  num_b,
    input  logic signed [rar_pkg::OPW-1:0]  den_b,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [rar_pkg::OW-1:0]   num_out,
    output logic signed [rar_pkg::OW-1:0]   den_out
);
    import rar_pkg::*;

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    raw_t  fq_data, qb_data;

    rar_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .operation(operation), .num_a(num_a), .den_a(den_a),
        .num_b(num_b), .den_b(den_b),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    rar_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    rar_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .valid(out_valid), .ready(out_ready),
        .num_out(num_out), .den_out(den_out)
    );

endmodule

[verif/tb_rational_arith_reduce.sv]
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce
// Drives signed fraction pairs through the reducer and checks every result
// word against a local predictor (exact products, Euclid GCD, per-side sign).
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce;
    import rar_pkg::*;

    class fraction_board;
        logic signed [32:0] pend_num[$];
        logic signed [32:0] pend_den[$];
        int errors = 0;

        function void note_input(logic [1:0] op, logic signed [15:0] na,
                                 logic signed [15:0] da, logic signed [15:0] nb,
                                 logic signed [15:0] db);
            longint rn, rd;
            longint unsigned mn, md, g, a, b, t;
            case (op)
                OP_ADD:  begin rn = na * db + nb * da; rd = da * db; end
                OP_SUB:  begin rn = na * db - nb * da; rd = da * db; end
                OP_MUL:  begin rn = na * nb; rd = da * db; end
                default: begin rn = na * db; rd = da * nb; end
            endcase
            mn = (rn < 0) ? -rn : rn;
            md = (rd < 0) ? -rd : rd;
            g = 1;
            if (mn != 0 && md != 0)
            begin
                a = mn;
                b = md;
                while (b != 0)
                begin
                    t = a % b;
                    a = b;
                    b = t;
                end
                g = a;
            end
            mn = mn / g;
            md = md / g;
            pend_num.push_back(33'((rn < 0) ? -mn : mn));
            pend_den.push_back(33'((rd < 0) ? -md : md));
        endfunction

        function void check_result(logic signed [32:0] n, logic signed [32:0] d);
            logic signed [32:0] en, ed;
            if (pend_num.size() == 0)
            begin
                $display("%0t: unexpected word num=%0d den=%0d", $time, n, d);
                errors++;
                return;
            end
            en = pend_num.pop_front();
            ed = pend_den.pop_front();
            if (n !== en)
            begin
                $display("%0t: num_out expected %0d actual %0d", $time, en, n);
                errors++;
            end
            if (d !== ed)
            begin
                $display("%0t: den_out expected %0d actual %0d", $time, ed, d);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] operation = OP_ADD;
    logic signed [15:0] num_a = 0, den_a = 0, num_b = 0, den_b = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [32:0] num_out, den_out;

    fraction_board board = new();
    bit hold_long = 0;
    int idle_cycles = 0;

    rational_arith_reduce dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_input(operation, num_a, den_a, num_b, den_b);
        if (rst_n && out_valid && out_ready)
            board.check_result(num_out, den_out);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'(int'($urandom_range(0, 12)) - 6);
            5: return 16'($urandom_range(0, 64) * 16);
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays up across back-to-back words; it drops only for a gap
    task automatic send_word(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                             logic [15:0] nb, logic [15:0] db);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op;
        num_a <= na;
        den_a <= da;
        num_b <= nb;
        den_b <= db;
        do @(posedge clk); while (!in_ready);
    endtask

    // receiver: random stalls, one long hold when requested
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_ready <= 0;
                repeat (2000) @(posedge clk);
                hold_long = 0;
            end
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        logic [15:0] edge_vals[4];
        int k;
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: every op at the extremes, zeros, zero denominators
        for (k = 0; k < 4; k++)
        begin
            send_word(k[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_word(k[1:0], 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001);
            send_word(k[1:0], 16'h0000, 16'h0005, 16'hFFFF, 16'h0000);
            send_word(k[1:0], 16'h0006, 16'hFFFC, 16'h0003, 16'h0009);
            send_word(k[1:0], edge_vals[k], 16'hFFFF, edge_vals[3 - k], 16'h7FFF);
        end
        send_word(OP_SUB, 16'h0003, 16'h0004, 16'h0003, 16'h0004);
        send_word(OP_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0004);
        // long receiver hold so the queue fills and input ready drops
        hold_long = 1;
        for (k = 0; k < 1028; k++)
        begin
            send_word(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
            if (k == 500)
            begin
                in_valid <= 0;
                @(negedge clk);
                wait (board.pend_num.size() == 0);
            end
        end
        in_valid <= 0;
        @(negedge clk);
        wait (board.pend_num.size() == 0);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pend_num.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[filelist.f]
rtl/rar_pkg.sv
rtl/rar_front.sv
rtl/rar_queue.sv
rtl/rar_back.sv
rtl/rational_arith_reduce.sv
verif/tb_rational_arith_reduce.sv
